// File: rtl/lip_pkg.sv
// Shared widths, register indexes and pipeline control types for the interpolation upsampler.
package lip_pkg;

   // Sample and configuration field widths.
   localparam int SAMPLE_W   = 16;
   localparam int STEP_W     = 17;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 17;

   // Configuration register indexes.
   localparam logic [CSR_ADDR_W-1:0] CSR_PHASE_STEP    = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_COMPLEX_MODE  = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_NARROW_OUTPUT = 2'd2;

   // Reset value of the phase step: one output per input.
   localparam logic [STEP_W-1:0] STEP_RESET = 17'h10000;

   // Offset between two's complement samples and the biased form used inside.
   localparam logic [SAMPLE_W-1:0] SAMPLE_BIAS = 16'h8000;

   // Control that travels alongside the lane data through the blend pipeline.
   typedef struct packed {
      logic valid;
      logic last;
      logic cplx;
      logic narrow;
   } ctl_type;

endpackage

// File: rtl/lip_lane.sv
// One blend lane: registered difference product, then base add and output formatting.
module lip_lane
   import lip_pkg::*;
#(
   parameter int FRAC_W = 16
) (
   input  logic                clock,
   input  logic                en,
   input  logic [SAMPLE_W-1:0] prev_b,
   input  logic [SAMPLE_W-1:0] new_b,
   input  logic [FRAC_W-1:0]   frac,
   input  logic                narrow,
   output logic [SAMPLE_W-1:0] value
);

   localparam int DIFF_W = SAMPLE_W + 1;
   localparam int PROD_W = DIFF_W + FRAC_W + 1;

   logic signed [DIFF_W-1:0] diff;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [PROD_W-1:0] prod_ff;
   logic [SAMPLE_W-1:0]      base_ff;
   logic signed [PROD_W-1:0] scaled;
   logic [DIFF_W-1:0]        sum;
   logic [SAMPLE_W-1:0]      blend;
   logic [7:0]               byte_val;

   // The blend prev*(1-t) + new*t equals prev + (new - prev)*t, floored.
   assign diff    = $signed({1'b0, new_b}) - $signed({1'b0, prev_b});
   assign prod_in = PROD_W'(diff) * $signed({1'b0, frac});

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
         base_ff <= prev_b;
      end
   end

   // Arithmetic shift floors the fractional product; the sum stays within the two samples.
   assign scaled   = prod_ff >>> FRAC_W;
   assign sum      = {1'b0, base_ff} + scaled[DIFF_W-1:0];
   assign blend    = sum[SAMPLE_W-1:0];

   // Remove the bias; in narrow mode keep the top byte and sign-extend it.
   assign byte_val = blend[SAMPLE_W-1:SAMPLE_W-8] ^ 8'h80;
   assign value    = narrow ? {{(SAMPLE_W-8){byte_val[7]}}, byte_val} : (blend ^ SAMPLE_BIAS);

endmodule

// File: rtl/lip_merge.sv
// Merging stage: combines the I and Q lanes into the registered result item.
module lip_merge
   import lip_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  ctl_type               ctl,
   input  logic [SAMPLE_W-1:0]   lane_i,
   input  logic [SAMPLE_W-1:0]   lane_q,
   output logic                  rsp_tvalid,
   output logic [2*SAMPLE_W-1:0] rsp_tdata,
   output logic                  rsp_tlast
);

   logic                  valid_ff;
   logic [2*SAMPLE_W-1:0] data_ff;
   logic                  last_ff;

   // Valid is control state; data and last only load with the pipeline.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= ctl.valid;
      end
   end

   // Real mode forces the quadrature output to zero.
   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= {(ctl.cplx ? lane_q : {SAMPLE_W{1'b0}}), lane_i};
         last_ff <= ctl.last;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;

endmodule

// File: rtl/linear_interp_upsampler_core.sv
// Top level of the linear interpolation upsampler: phase sequencer, two blend lanes, merge.
//
//   channel  dir  handshake             payload
//   req      in   req_tvalid/tready     tdata: sample_i, sample_q
//   rsp      out  rsp_tvalid/tready     tdata: out_i, out_q; tlast: burst_last
//   csr      in   csr_wen               csr_addr, csr_wdata (no read-back)
//
// An input item is accepted only in idle; the sequencer then issues all its results before it
// takes the next item, one blend per cycle to both lanes while the output is not stalled.
// Results pass the lane product register, then the merge output register. While rsp_tvalid is
// high and rsp_tready low, the blend pipeline and running sequencer hold. Synchronous reset
// restores config defaults, zeroes phase and previous samples; no clearing pass is needed.
module linear_interp_upsampler_core
   import lip_pkg::*;
#(
   parameter int MAX_RATIO       = 64,
   parameter int PHASE_FRAC_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   // Input items.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [2*SAMPLE_W-1:0] req_tdata,   // [15:0] sample_i, [31:16] sample_q
   // Result items.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [2*SAMPLE_W-1:0] rsp_tdata,   // [15:0] out_i, [31:16] out_q
   output logic                  rsp_tlast,   // burst_last
   // Configuration writes.
   input  logic                  csr_wen,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int PH_W  = PHASE_FRAC_BITS + 1;
   localparam int CMP_W = (STEP_W > PH_W) ? STEP_W : PH_W;
   localparam int CNT_W = (MAX_RATIO > 1) ? $clog2(MAX_RATIO) : 1;
   localparam logic [CMP_W-1:0] ONE_C      = CMP_W'(1) << PHASE_FRAC_BITS;
   localparam logic [CMP_W-1:0] MIN_STEP_C =
      CMP_W'(((64'd1 << PHASE_FRAC_BITS) + 64'(MAX_RATIO) - 64'd1) / 64'(MAX_RATIO));
   localparam logic [PH_W-1:0]  ONE_P      = PH_W'(1) << PHASE_FRAC_BITS;
   localparam logic [CNT_W-1:0] LAST_CNT   = CNT_W'(MAX_RATIO - 1);

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   // Configuration registers.
   logic [STEP_W-1:0] step_cfg_ff;
   logic              cplx_ff;
   logic              narrow_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_cfg_ff <= STEP_RESET;
         cplx_ff     <= 1'b0;
         narrow_ff   <= 1'b0;
      end else if (csr_wen) begin
         case (csr_addr)
            CSR_PHASE_STEP:    step_cfg_ff <= csr_wdata[STEP_W-1:0];
            CSR_COMPLEX_MODE:  cplx_ff     <= csr_wdata[0];
            CSR_NARROW_OUTPUT: narrow_ff   <= csr_wdata[0];
            default:           ;
         endcase
      end
   end

   // Clamp the step between the minimum for the largest ratio and one.
   logic [CMP_W-1:0] step_wide;
   logic [CMP_W-1:0] step_clamp;

   assign step_wide  = CMP_W'(step_cfg_ff);
   assign step_clamp = (step_wide < MIN_STEP_C) ? MIN_STEP_C :
                       (step_wide > ONE_C)      ? ONE_C      : step_wide;

   // Sequencer state.
   state_type           state_ff;
   logic [PH_W-1:0]     phase_ff;
   logic [PH_W-1:0]     step_ff;
   logic [CNT_W-1:0]    cnt_ff;
   logic [SAMPLE_W-1:0] prev_i_ff;
   logic [SAMPLE_W-1:0] prev_q_ff;
   logic [SAMPLE_W-1:0] new_i_ff;
   logic [SAMPLE_W-1:0] new_q_ff;
   ctl_type             s1_ctl_ff;

   logic            pipe_en;
   logic            below_one;
   logic [PH_W-1:0] phase_sum;
   logic            sum_wraps;
   logic            issue_last;

   // The pipeline moves when the output register is empty or being drained.
   assign pipe_en    = !rsp_tvalid || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign below_one  = (phase_ff < ONE_P);
   assign phase_sum  = phase_ff + step_ff;
   assign sum_wraps  = (phase_sum >= ONE_P);
   assign issue_last = sum_wraps || (cnt_ff == LAST_CNT);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         phase_ff        <= '0;
         cnt_ff          <= '0;
         prev_i_ff       <= SAMPLE_BIAS;
         prev_q_ff       <= SAMPLE_BIAS;
         s1_ctl_ff.valid <= 1'b0;
      end else begin
         // Control payload of the first stage travels with the lane products.
         if (pipe_en) begin
            s1_ctl_ff.valid  <= (state_ff == ST_RUN) && below_one;
            s1_ctl_ff.last   <= issue_last;
            s1_ctl_ff.cplx   <= cplx_ff;
            s1_ctl_ff.narrow <= narrow_ff;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  new_i_ff <= req_tdata[SAMPLE_W-1:0] ^ SAMPLE_BIAS;
                  new_q_ff <= req_tdata[2*SAMPLE_W-1:SAMPLE_W] ^ SAMPLE_BIAS;
                  step_ff  <= step_clamp[PH_W-1:0];
                  cnt_ff   <= '0;
                  state_ff <= ST_RUN;
               end
            end
            ST_RUN: begin
               if (pipe_en) begin
                  if (!below_one) begin
                     // Phase at or past one: no result, just move on.
                     phase_ff  <= phase_ff - ONE_P;
                     prev_i_ff <= new_i_ff;
                     prev_q_ff <= new_q_ff;
                     state_ff  <= ST_IDLE;
                  end else if (issue_last) begin
                     phase_ff  <= sum_wraps ? (phase_sum - ONE_P) : '0;
                     prev_i_ff <= new_i_ff;
                     prev_q_ff <= new_q_ff;
                     state_ff  <= ST_IDLE;
                  end else begin
                     phase_ff <= phase_sum;
                     cnt_ff   <= cnt_ff + CNT_W'(1);
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // Two lanes blend I and Q in parallel.
   logic [SAMPLE_W-1:0] lane_i;
   logic [SAMPLE_W-1:0] lane_q;

   lip_lane #(
      .FRAC_W (PHASE_FRAC_BITS)
   ) u_lane_i (
      .clock  (clock),
      .en     (pipe_en),
      .prev_b (prev_i_ff),
      .new_b  (new_i_ff),
      .frac   (phase_ff[PHASE_FRAC_BITS-1:0]),
      .narrow (s1_ctl_ff.narrow),
      .value  (lane_i)
   );

   lip_lane #(
      .FRAC_W (PHASE_FRAC_BITS)
   ) u_lane_q (
      .clock  (clock),
      .en     (pipe_en),
      .prev_b (prev_q_ff),
      .new_b  (new_q_ff),
      .frac   (phase_ff[PHASE_FRAC_BITS-1:0]),
      .narrow (s1_ctl_ff.narrow),
      .value  (lane_q)
   );

   lip_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .en         (pipe_en),
      .ctl        (s1_ctl_ff),
      .lane_i     (lane_i),
      .lane_q     (lane_q),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
